>>> rtl/scc_pkg.sv
// Shared types and constants for the serial command clock.
// Used by scc_clock and serial_command_clock; depends on nothing.
package scc_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_CAPTURE = 2'd1,
    MODE_LED     = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_CLEAR = 3'd1,
    ACT_SHOW  = 3'd2,
    ACT_TIME  = 3'd3,
    ACT_TICK  = 3'd4
  } action_t;

  localparam logic [7:0] CHR_HASH  = 8'h23;
  localparam logic [7:0] CHR_AMP   = 8'h26;
  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_A     = 8'h41;
  localparam logic [7:0] CHR_B     = 8'h42;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;

  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [6:0] HOURS_PER_DAY = 7'd24;
  localparam logic [6:0] MINS_PER_HOUR = 7'd60;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } tod_t;

  typedef struct packed {
    logic tick;
    logic load;
    tod_t load_val;
  } clk_ctl_t;

endpackage

>>> rtl/serial_command_clock.sv
// Top level: input word register, command parser, time capture check, result register.
// Depends on scc_pkg and scc_clock.
//
//   channel  ports                                         role
//   in       in_valid in_stall in_opcode in_rx_byte ...    byte or tick with sample
//   out      out_valid out_stall out_action ...            one result word per input
//
// One word per cycle unless stalled; out_valid marks a word in the result register.
// The parser and the clock update as a word moves from the input register
// into the result register. Reset clears mode, index, clock and LED.
// in_stall rises only while both registers are full and out_stall is high.
module serial_command_clock (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic [11:0] in_adc_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [7:0]  out_display_char,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds,
  output logic        out_led_on,
  output logic [11:0] out_adc_value
);
  import scc_pkg::*;

  logic        s0_valid_r;
  logic        s0_opcode_r;
  logic [7:0]  s0_byte_r;
  logic [11:0] s0_sample_r;
  logic        out_valid_r;
  logic        accept;
  logic        advance;

  mode_t       mode_r, mode_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        led_r, led_nxt;
  logic [7:0]  cap_buf_r [8];
  logic        buf_we;

  clk_ctl_t    ctl;
  tod_t        tod_nxt;
  action_t     act;
  logic [7:0]  shown;
  logic [11:0] adc;

  logic [7:0]  cap [8];
  logic        digits_ok;
  logic [6:0]  h_val, m_val, s_val;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHR_ZERO) && (c <= CHR_NINE);
  endfunction

  function automatic logic [6:0] two_digits(input logic [3:0] hi, input logic [3:0] lo);
    return {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
  endfunction

  assign advance  = s0_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s0_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      cap[i] = cap_buf_r[i];
    end
    cap[7] = s0_byte_r;
  end

  assign digits_ok = is_digit(cap[0]) && is_digit(cap[1]) && is_digit(cap[3]) &&
                     is_digit(cap[4]) && is_digit(cap[6]) && is_digit(cap[7]);
  assign h_val = two_digits(cap[0][3:0], cap[1][3:0]);
  assign m_val = two_digits(cap[3][3:0], cap[4][3:0]);
  assign s_val = two_digits(cap[6][3:0], cap[7][3:0]);

  always_comb begin
    mode_nxt = mode_r;
    idx_nxt  = idx_r;
    led_nxt  = led_r;
    buf_we   = 1'b0;
    act      = ACT_NONE;
    shown    = '0;
    adc      = '0;
    ctl.tick = 1'b0;
    ctl.load = 1'b0;
    ctl.load_val.hours   = h_val[4:0];
    ctl.load_val.minutes = m_val[5:0];
    ctl.load_val.seconds = s_val[5:0];
    if (s0_opcode_r) begin
      ctl.tick = 1'b1;
      act      = ACT_TICK;
      adc      = s0_sample_r;
    end else begin
      case (mode_r)
        MODE_CAPTURE: begin
          buf_we = 1'b1;
          if (idx_r == 3'd7) begin
            idx_nxt  = '0;
            mode_nxt = MODE_IDLE;
            if (digits_ok && (h_val < HOURS_PER_DAY) && (m_val < MINS_PER_HOUR) &&
                (s_val < MINS_PER_HOUR)) begin
              ctl.load = 1'b1;
              act      = ACT_TIME;
            end
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        MODE_LED: begin
          if (s0_byte_r == CHR_A) begin
            led_nxt = 1'b1;
          end else if (s0_byte_r == CHR_B) begin
            led_nxt = 1'b0;
          end
          mode_nxt = MODE_IDLE;
        end
        default: begin
          mode_nxt = MODE_IDLE;
          if (s0_byte_r == CHR_HASH) begin
            act = ACT_CLEAR;
          end else if (s0_byte_r == CHR_AMP) begin
            mode_nxt = MODE_CAPTURE;
            idx_nxt  = '0;
          end else if (s0_byte_r == CHR_STAR) begin
            mode_nxt = MODE_LED;
          end else if (s0_byte_r != CHR_LF && s0_byte_r != CHR_CR) begin
            act   = ACT_SHOW;
            shown = s0_byte_r;
          end
        end
      endcase
    end
  end

  scc_clock u_clock (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .ctl     (ctl),
    .tod_nxt (tod_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_IDLE;
      idx_r       <= '0;
      led_r       <= 1'b0;
    end else begin
      if (accept) begin
        s0_valid_r <= 1'b1;
      end else if (advance) begin
        s0_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        mode_r      <= mode_nxt;
        idx_r       <= idx_nxt;
        led_r       <= led_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_opcode_r <= in_opcode;
      s0_byte_r   <= in_rx_byte;
      s0_sample_r <= in_adc_sample;
    end
    if (advance && buf_we) begin
      cap_buf_r[idx_r] <= s0_byte_r;
    end
    if (advance) begin
      out_action       <= act;
      out_display_char <= shown;
      out_hours        <= tod_nxt.hours;
      out_minutes      <= tod_nxt.minutes;
      out_seconds      <= tod_nxt.seconds;
      out_led_on       <= led_nxt;
      out_adc_value    <= adc;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/scc_clock.sv
// Time-of-day counter: one-second advance with wrap, or load of a checked time.
// Depends on scc_pkg.
module scc_clock (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  scc_pkg::clk_ctl_t ctl,
  output scc_pkg::tod_t     tod_nxt
);
  import scc_pkg::*;

  tod_t tod_r;
  tod_t adv;

  always_comb begin
    adv = tod_r;
    if (tod_r.seconds >= MIN_MAX) begin
      adv.seconds = '0;
      if (tod_r.minutes >= MIN_MAX) begin
        adv.minutes = '0;
        if (tod_r.hours >= HOUR_MAX) begin
          adv.hours = '0;
        end else begin
          adv.hours = tod_r.hours + 5'd1;
        end
      end else begin
        adv.minutes = tod_r.minutes + 6'd1;
      end
    end else begin
      adv.seconds = tod_r.seconds + 6'd1;
    end
  end

  always_comb begin
    tod_nxt = tod_r;
    if (en && ctl.tick) begin
      tod_nxt = adv;
    end else if (en && ctl.load) begin
      tod_nxt = ctl.load_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tod_r <= '0;
    end else begin
      tod_r <= tod_nxt;
    end
  end

endmodule

>>> tb/scc_tb_pkg.sv
`timescale 1ns / 100ps
// Result word type and scoreboard for the serial command clock testbench.
// Depends on scc_pkg for the mode and action codes and the character constants.
package scc_tb_pkg;
  import scc_pkg::*;

  localparam logic [7:0] CHR_COLON = 8'h3A;

  typedef struct {
    logic [2:0]  action;
    logic [7:0]  display_char;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic        led_on;
    logic [11:0] adc_value;
  } clock_word_t;

  class clock_scoreboard;
    mode_t       mode;
    logic [2:0]  slot;
    logic [7:0]  capture [8];
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
    logic        led;
    clock_word_t expected_q[$];
    int          errors;

    function new();
      mode = MODE_IDLE;
      slot = '0;
      hh = '0;
      mm = '0;
      ss = '0;
      led = 1'b0;
      errors = 0;
      foreach (capture[i]) capture[i] = '0;
    endfunction

    function bit load_capture();
      int h;
      int m;
      int s;
      for (int i = 0; i < 8; i++) begin
        if (i != 2 && i != 5 && (capture[i] < CHR_ZERO || capture[i] > CHR_NINE)) return 1'b0;
      end
      h = (int'(capture[0]) - int'(CHR_ZERO)) * 10 + int'(capture[1]) - int'(CHR_ZERO);
      m = (int'(capture[3]) - int'(CHR_ZERO)) * 10 + int'(capture[4]) - int'(CHR_ZERO);
      s = (int'(capture[6]) - int'(CHR_ZERO)) * 10 + int'(capture[7]) - int'(CHR_ZERO);
      if (h >= int'(HOURS_PER_DAY) || m >= int'(MINS_PER_HOUR) || s >= int'(MINS_PER_HOUR))
        return 1'b0;
      hh = h[4:0];
      mm = m[5:0];
      ss = s[5:0];
      return 1'b1;
    endfunction

    function void advance_time();
      ss = ss + 6'd1;
      if (ss > MIN_MAX) begin
        ss = '0;
        mm = mm + 6'd1;
        if (mm > MIN_MAX) begin
          mm = '0;
          hh = hh + 5'd1;
          if (hh > HOUR_MAX) hh = '0;
        end
      end
    endfunction

    function void note_word(logic opcode, logic [7:0] rx, logic [11:0] sample);
      clock_word_t w;
      w.action = ACT_NONE;
      w.display_char = '0;
      w.adc_value = '0;
      if (opcode) begin
        advance_time();
        w.action = ACT_TICK;
        w.adc_value = sample;
      end else if (mode == MODE_CAPTURE) begin
        capture[slot] = rx;
        if (slot == 3'd7) begin
          slot = '0;
          mode = MODE_IDLE;
          if (load_capture()) w.action = ACT_TIME;
        end else begin
          slot = slot + 3'd1;
        end
      end else if (mode == MODE_LED) begin
        if (rx == CHR_A) led = 1'b1;
        else if (rx == CHR_B) led = 1'b0;
        mode = MODE_IDLE;
      end else begin
        mode = MODE_IDLE;
        case (rx)
          CHR_HASH: w.action = ACT_CLEAR;
          CHR_AMP: begin
            mode = MODE_CAPTURE;
            slot = '0;
          end
          CHR_STAR: mode = MODE_LED;
          CHR_LF, CHR_CR: ;
          default: begin
            w.action = ACT_SHOW;
            w.display_char = rx;
          end
        endcase
      end
      w.hours = hh;
      w.minutes = mm;
      w.seconds = ss;
      w.led_on = led;
      expected_q.push_back(w);
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(clock_word_t got);
      clock_word_t w;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      w = expected_q.pop_front();
      compare("action", 32'(w.action), 32'(got.action));
      compare("display_char", 32'(w.display_char), 32'(got.display_char));
      compare("hours", 32'(w.hours), 32'(got.hours));
      compare("minutes", 32'(w.minutes), 32'(got.minutes));
      compare("seconds", 32'(w.seconds), 32'(got.seconds));
      compare("led_on", 32'(w.led_on), 32'(got.led_on));
      compare("adc_value", 32'(w.adc_value), 32'(got.adc_value));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

>>> tb/serial_command_clock_tb.sv
`timescale 1ns / 100ps
// Top of the serial command clock testbench: clock, reset, word driver, result monitor.
// Depends on scc_pkg, scc_tb_pkg and the serial_command_clock RTL.
module serial_command_clock_tb;
  import scc_pkg::*;
  import scc_tb_pkg::*;

  localparam int RANDOM_WORDS = 1450;
  localparam int DIRECTED_WORDS = 24;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic [11:0] in_adc_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_action;
  logic [7:0]  out_display_char;
  logic [4:0]  out_hours;
  logic [5:0]  out_minutes;
  logic [5:0]  out_seconds;
  logic        out_led_on;
  logic [11:0] out_adc_value;

  clock_scoreboard sb;
  int sent = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  serial_command_clock u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_rx_byte       (in_rx_byte),
    .in_adc_sample    (in_adc_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_action       (out_action),
    .out_display_char (out_display_char),
    .out_hours        (out_hours),
    .out_minutes      (out_minutes),
    .out_seconds      (out_seconds),
    .out_led_on       (out_led_on),
    .out_adc_value    (out_adc_value)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic send_word(input logic op, input logic [7:0] rx, input logic [11:0] sample);
    while (idle_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_rx_byte <= rx;
    in_adc_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(op, rx, sample);
    sent++;
    idle_on = !(sent >= 700 && sent < 1000);
    if (sent == 400) hold_req = 1'b1;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] rx);
    send_word(1'b0, rx, 12'($urandom_range(4095)));
  endtask

  task automatic send_tick(input logic [11:0] sample);
    send_word(1'b1, 8'($urandom_range(255)), sample);
  endtask

  function automatic int pick_field(int max_ok);
    int r;
    r = $urandom_range(9);
    if (r < 3) return max_ok;
    if (r == 3) return $urandom_range(99, max_ok + 1);
    return $urandom_range(max_ok, 0);
  endfunction

  task automatic send_capture();
    logic [7:0] chars [8];
    int h;
    int m;
    int s;
    int n;
    int pos;
    h = pick_field(int'(HOUR_MAX));
    m = pick_field(int'(MIN_MAX));
    s = pick_field(int'(MIN_MAX));
    chars[0] = CHR_ZERO + 8'(h / 10);
    chars[1] = CHR_ZERO + 8'(h % 10);
    chars[2] = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : CHR_COLON;
    chars[3] = CHR_ZERO + 8'(m / 10);
    chars[4] = CHR_ZERO + 8'(m % 10);
    chars[5] = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : CHR_COLON;
    chars[6] = CHR_ZERO + 8'(s / 10);
    chars[7] = CHR_ZERO + 8'(s % 10);
    if ($urandom_range(9) == 0) begin
      pos = $urandom_range(5);
      pos = pos + (pos >= 2) + (pos >= 4);
      chars[pos] = 8'($urandom_range(255));
    end
    n = ($urandom_range(19) == 0) ? $urandom_range(7) : 8;
    send_byte(CHR_AMP);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) send_tick(12'($urandom_range(4095)));
      send_byte(chars[i]);
    end
    if (h == int'(HOUR_MAX) && $urandom_range(1) == 0) begin
      repeat ($urandom_range(12, 1)) send_tick(12'($urandom_range(4095)));
    end
  endtask

  task automatic send_led_command();
    int r;
    r = $urandom_range(9);
    send_byte(CHR_STAR);
    if ($urandom_range(19) == 0) send_tick(12'($urandom_range(4095)));
    if (r < 4) send_byte(CHR_A);
    else if (r < 8) send_byte(CHR_B);
    else send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    int r;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_byte(CHR_HASH);
    send_byte(8'h5A);
    send_byte(CHR_CR);
    send_byte(CHR_LF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CHR_STAR);
    send_byte(CHR_A);
    send_byte(CHR_STAR);
    send_byte(CHR_B);
    send_byte(CHR_AMP);
    send_byte(CHR_ZERO + 8'd2);
    send_byte(CHR_ZERO + 8'd3);
    send_byte(CHR_COLON);
    send_byte(CHR_ZERO + 8'd5);
    send_tick(12'hFFF);
    send_byte(CHR_NINE);
    send_byte(8'hFF);
    send_byte(CHR_ZERO + 8'd5);
    send_byte(CHR_NINE);
    send_tick(12'h000);
    send_byte(CHR_STAR);
    send_tick(12'($urandom_range(4095)));
    send_byte(8'h43);

    while (sent < DIRECTED_WORDS + RANDOM_WORDS) begin
      r = $urandom_range(99);
      if (r < 20) send_tick(12'($urandom_range(4095)));
      else if (r < 45) send_capture();
      else if (r < 60) send_led_command();
      else if (r < 65) send_byte(CHR_HASH);
      else if (r < 72) send_byte($urandom_range(1) ? CHR_CR : CHR_LF);
      else send_byte(8'($urandom_range(255)));
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 8);
      end
    end
  end

  always @(posedge clk) begin
    clock_word_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.action = out_action;
      got.display_char = out_display_char;
      got.hours = out_hours;
      got.minutes = out_minutes;
      got.seconds = out_seconds;
      got.led_on = out_led_on;
      got.adc_value = out_adc_value;
      sb.check_word(got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
